FILE: hdl/cvtg_pkg.sv
// ----------------------------------------------------------------------------
// cvtg_pkg
// Shared types and constants of the composite video timing generator.
// ----------------------------------------------------------------------------
package cvtg_pkg;

  localparam int unsigned FRONT_PORCH_LINES = 2;
  localparam int unsigned VSYNC_LINES       = 2;
  localparam int unsigned LINE_BUFFER_DEPTH = 1024;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 40;

  // line offsets after the end of active video, widened so they never wrap
  localparam logic [9:0] VSYNC_ON_OFFSET  = 10'(FRONT_PORCH_LINES + 1);
  localparam logic [9:0] VSYNC_OFF_OFFSET = 10'(FRONT_PORCH_LINES + 1 + VSYNC_LINES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINE_PERIOD      = 3'd0,
    CFG_SHORT_SYNC_END   = 3'd1,
    CFG_LONG_SYNC_END    = 3'd2,
    CFG_LINE_EVENT_POINT = 3'd3,
    CFG_PIXEL_PERIOD     = 3'd4,
    CFG_PIXELS_PER_LINE  = 3'd5,
    CFG_VISIBLE_LINES    = 3'd6,
    CFG_FRAME_LINES      = 3'd7
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] line_period;
    logic [15:0] short_sync_end;
    logic [15:0] long_sync_end;
    logic [15:0] line_event_point;
    logic [7:0]  pixel_period;
    logic [9:0]  pixels_per_line;
    logic [8:0]  visible_lines;
    logic [8:0]  frame_lines;
  } cfg_t;

  typedef struct packed {
    logic        blanked;
    logic        line_start;
    logic [15:0] frame_count;
    logic [8:0]  line_number;
    logic        buffer_select;
    logic [9:0]  pixel_index;
    logic        pixel_strobe;
    logic        sync_level;
  } result_t;

endpackage

FILE: hdl/composite_video_timing_generator_unit.sv
// ----------------------------------------------------------------------------
// composite_video_timing_generator_unit
// Composite sync and pixel strobe timing, one timer tick per transaction.
// ----------------------------------------------------------------------------
// path: an accepted tick is held in the input register, and its result is taken
//   into the result register once that slot is free or being drained
// throughput: one tick per cycle unless m_axis_tready stalls, set by the input
//   register feeding the timing update and the result register behind it
// reset: all counters and flags clear, registers take their default timing,
//   both streams come up empty
module composite_video_timing_generator_unit
  import cvtg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // slave stream, tdata: tick [0], zero fill [7:1]
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // master stream, tdata: sync_level, pixel_strobe, pixel_index[9:0],
  //   buffer_select, line_number[8:0], frame_count[15:0], line_start, blanked
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  cfg_t    cfg;
  result_t res;

  logic    in_valid_q;
  logic    tick_q;
  logic    out_valid_q;
  result_t out_q;
  logic    advance;

  assign cfg_ready_o = 1'b1;

  cvtg_cfg u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_idx_i  (cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // item moves on when the result slot is free or being drained
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  cvtg_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .tick_i (tick_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      tick_q <= s_axis_tdata[0];
    end
    if (advance) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_q.blanked, out_q.line_start, out_q.frame_count,
                          out_q.line_number, out_q.buffer_select, out_q.pixel_index,
                          out_q.pixel_strobe, out_q.sync_level};

endmodule

FILE: hdl/cvtg_cfg.sv
// ----------------------------------------------------------------------------
// cvtg_cfg
// Configuration register file, written one register per transaction.
// ----------------------------------------------------------------------------
module cvtg_cfg
  import cvtg_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  wr_en_i,
  input  logic [CFG_IDX_W-1:0]  wr_idx_i,
  input  logic [CFG_DATA_W-1:0] wr_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.line_period      <= 16'd4608;
      cfg_q.short_sync_end   <= 16'd281;
      cfg_q.long_sync_end    <= 16'd4326;
      cfg_q.line_event_point <= 16'd859;
      cfg_q.pixel_period     <= 8'd14;
      cfg_q.pixels_per_line  <= 10'd245;
      cfg_q.visible_lines    <= 9'd224;
      cfg_q.frame_lines      <= 9'd253;
    end else if (wr_en_i) begin
      case (cfg_idx_e'(wr_idx_i))
        CFG_LINE_PERIOD:      cfg_q.line_period      <= wr_data_i;
        CFG_SHORT_SYNC_END:   cfg_q.short_sync_end   <= wr_data_i;
        CFG_LONG_SYNC_END:    cfg_q.long_sync_end    <= wr_data_i;
        CFG_LINE_EVENT_POINT: cfg_q.line_event_point <= wr_data_i;
        CFG_PIXEL_PERIOD:     cfg_q.pixel_period     <= wr_data_i[7:0];
        CFG_PIXELS_PER_LINE:  cfg_q.pixels_per_line  <= wr_data_i[9:0];
        CFG_VISIBLE_LINES:    cfg_q.visible_lines    <= wr_data_i[8:0];
        CFG_FRAME_LINES:      cfg_q.frame_lines      <= wr_data_i[8:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: hdl/cvtg_core.sv
// ----------------------------------------------------------------------------
// cvtg_core
// Timing state and its one-tick update: horizontal counter, line event,
// frame and sync control, pixel strobe run.
// ----------------------------------------------------------------------------
module cvtg_core
  import cvtg_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    step_i,
  input  logic    tick_i,
  input  cfg_t    cfg_i,
  output result_t res_o
);

  logic [15:0] hcount_q, hcount_d;
  logic [8:0]  line_q, line_d;
  logic        long_sync_q, long_sync_d;
  logic        disp_sel_q, disp_sel_d;
  logic [15:0] frames_q, frames_d;
  logic [7:0]  phase_q, phase_d;
  logic [9:0]  sent_q, sent_d;
  logic        run_q, run_d;

  logic [8:0]  next_line;
  logic [9:0]  vis_ext;
  logic [16:0] hcount_inc;
  logic        in_line;
  logic        start;
  logic        strobe;
  logic [9:0]  index;
  logic        running;
  logic [15:0] pulse_end;

  always_comb begin
    hcount_d    = hcount_q;
    line_d      = line_q;
    long_sync_d = long_sync_q;
    disp_sel_d  = disp_sel_q;
    frames_d    = frames_q;
    phase_d     = phase_q;
    sent_d      = sent_q;
    run_d       = run_q;
    start       = 1'b0;
    strobe      = 1'b0;
    index       = '0;

    next_line  = line_q + 9'd1;
    vis_ext    = {1'b0, cfg_i.visible_lines};
    hcount_inc = {1'b0, hcount_q} + 17'd1;
    in_line    = (cfg_i.line_period == '0) || (cfg_i.line_event_point < cfg_i.line_period);

    if (tick_i) begin
      if (in_line && (hcount_q == cfg_i.line_event_point)) begin
        start = 1'b1;
        if (next_line < cfg_i.visible_lines) begin
          disp_sel_d = ~disp_sel_q;
          phase_d    = '0;
          sent_d     = '0;
          run_d      = (cfg_i.pixels_per_line != '0);
        end else if (next_line == cfg_i.visible_lines) begin
          frames_d = frames_q + 16'd1;
        end else if ({1'b0, next_line} == vis_ext + VSYNC_ON_OFFSET) begin
          long_sync_d = 1'b1;
        end else if ({1'b0, next_line} == vis_ext + VSYNC_OFF_OFFSET) begin
          long_sync_d = 1'b0;
        end else if (next_line >= cfg_i.frame_lines) begin
          next_line = '0;
        end
        line_d = next_line;
      end
    end

    // run flag after any restart by the line event
    running = run_d;

    if (tick_i) begin
      if (run_d) begin
        if (phase_d == '0) begin
          strobe = 1'b1;
          index  = 10'(sent_d % LINE_BUFFER_DEPTH);
          sent_d = sent_d + 10'd1;
          if (sent_d >= cfg_i.pixels_per_line) begin
            run_d = 1'b0;
          end
        end
        phase_d = phase_d + 8'd1;
        if (phase_d >= cfg_i.pixel_period) begin
          phase_d = '0;
        end
      end
      // a zero line period behaves as a full 16-bit wrap
      if ((cfg_i.line_period != '0) && (hcount_inc >= {1'b0, cfg_i.line_period})) begin
        hcount_d = '0;
      end else begin
        hcount_d = hcount_inc[15:0];
      end
    end

    pulse_end = long_sync_d ? cfg_i.long_sync_end : cfg_i.short_sync_end;

    res_o.sync_level    = !(hcount_q < pulse_end);
    res_o.pixel_strobe  = strobe;
    res_o.pixel_index   = index;
    res_o.buffer_select = disp_sel_d;
    res_o.line_number   = line_d;
    res_o.frame_count   = frames_d;
    res_o.line_start    = start;
    res_o.blanked       = !running;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hcount_q    <= '0;
      line_q      <= '0;
      long_sync_q <= 1'b0;
      disp_sel_q  <= 1'b0;
      frames_q    <= '0;
      phase_q     <= '0;
      sent_q      <= '0;
      run_q       <= 1'b0;
    end else if (step_i) begin
      hcount_q    <= hcount_d;
      line_q      <= line_d;
      long_sync_q <= long_sync_d;
      disp_sel_q  <= disp_sel_d;
      frames_q    <= frames_d;
      phase_q     <= phase_d;
      sent_q      <= sent_d;
      run_q       <= run_d;
    end
  end

endmodule

FILE: tb/composite_video_timing_generator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// composite_video_timing_generator_unit_tb
// Self-checking bench for the composite sync and pixel strobe timing unit.
// Ticks are streamed in under random gaps, each returned transaction is
// compared against an in-bench timing predictor, and the timing registers
// are reloaded between phases covering extreme and random line setups.
// ----------------------------------------------------------------------------
module composite_video_timing_generator_unit_tb;
  import cvtg_pkg::*;

  localparam int unsigned QUIET_LIMIT   = 2000;
  localparam int unsigned REPORT_LIMIT  = 10;
  localparam logic [5:0]  RESET_PATTERN = 6'b011010;

  typedef struct packed {
    cfg_idx_e    idx;
    logic [15:0] val;
  } reg_write_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  composite_video_timing_generator_unit u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // timing registers and state as the predictor sees them
  cfg_t timing_regs = '{16'd4608, 16'd281, 16'd4326, 16'd859, 8'd14, 10'd245, 9'd224, 9'd253};
  logic [15:0] h_cnt     = '0;
  logic [8:0]  line_cnt  = '0;
  logic        long_sync = 1'b0;
  logic        disp_sel  = 1'b0;
  logic [15:0] frames    = '0;
  logic [7:0]  pix_phase = '0;
  logic [9:0]  pix_sent  = '0;
  logic        pix_run   = 1'b0;

  logic       tick_q[$];
  reg_write_t reg_writes[$];
  result_t    expected_results[$];

  logic        idle_en   = 1'b0;
  logic        hold_go   = 1'b0;
  logic        hold_used;
  logic [6:0]  hold_cnt;
  logic        rx_hold;
  int unsigned tx_wait, rx_wait, quiet;
  int unsigned ticks_taken, results_seen, mismatches, line_events, strobes, setups;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  function automatic result_t advance_timing(input logic tick);
    cfg_t        c;
    logic [15:0] h;
    logic [8:0]  nl;
    logic        running;
    result_t     r;
    c = timing_regs;
    h = h_cnt;
    r = '0;
    running = pix_run;
    if (tick) begin
      // a line event only exists when the event point falls inside the line
      if ((c.line_period == 16'd0 || c.line_event_point < c.line_period) &&
          h == c.line_event_point) begin
        r.line_start = 1'b1;
        nl = line_cnt + 9'd1;
        if (nl < c.visible_lines) begin
          disp_sel  = ~disp_sel;
          pix_phase = '0;
          pix_sent  = '0;
          pix_run   = (c.pixels_per_line != 10'd0);
        end else if (nl == c.visible_lines) begin
          frames = frames + 16'd1;
        end else if (int'(nl) == int'(c.visible_lines) + FRONT_PORCH_LINES + 1) begin
          long_sync = 1'b1;
        end else if (int'(nl) ==
                     int'(c.visible_lines) + FRONT_PORCH_LINES + VSYNC_LINES + 1) begin
          long_sync = 1'b0;
        end else if (nl >= c.frame_lines) begin
          nl = '0;
        end
        line_cnt = nl;
      end
      running = pix_run;
      if (pix_run) begin
        if (pix_phase == 8'd0) begin
          r.pixel_strobe = 1'b1;
          r.pixel_index  = 10'(pix_sent % LINE_BUFFER_DEPTH);
          pix_sent       = pix_sent + 10'd1;
          if (pix_sent >= c.pixels_per_line) pix_run = 1'b0;
        end
        pix_phase = pix_phase + 8'd1;
        if (pix_phase >= c.pixel_period) pix_phase = '0;
      end
      // zero line period behaves as a full 16-bit wrap
      if (c.line_period != 16'd0 && 17'(h) + 17'd1 >= 17'(c.line_period)) begin
        h_cnt = '0;
      end else begin
        h_cnt = h + 16'd1;
      end
    end
    r.sync_level    = (h >= (long_sync ? c.long_sync_end : c.short_sync_end));
    r.buffer_select = disp_sel;
    r.line_number   = line_cnt;
    r.frame_count   = frames;
    r.blanked       = ~running;
    return r;
  endfunction

  // tick driver
  always @(posedge clk_i or negedge rst_ni) begin : tick_driver
    logic t;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      tx_wait       <= 0;
      ticks_taken   <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        expected_results.push_back(advance_timing(s_axis_tdata[0]));
        ticks_taken <= ticks_taken + 1;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (tx_wait != 0) begin
          tx_wait       <= tx_wait - 1;
          s_axis_tvalid <= 1'b0;
        end else if (tick_q.size() != 0) begin
          t = tick_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {{(IN_DATA_W-1){1'b0}}, t};
          tx_wait       <= idle_en ? $urandom_range(0, 7) : 0;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // register write driver, shadow copy follows each accepted write
  always @(posedge clk_i or negedge rst_ni) begin : reg_driver
    reg_write_t w;
    if (!rst_ni) begin
      cfg_valid_i <= 1'b0;
      cfg_index_i <= CFG_LINE_PERIOD;
      cfg_data_i  <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_LINE_PERIOD:      timing_regs.line_period      = cfg_data_i;
          CFG_SHORT_SYNC_END:   timing_regs.short_sync_end   = cfg_data_i;
          CFG_LONG_SYNC_END:    timing_regs.long_sync_end    = cfg_data_i;
          CFG_LINE_EVENT_POINT: timing_regs.line_event_point = cfg_data_i;
          CFG_PIXEL_PERIOD:     timing_regs.pixel_period     = cfg_data_i[7:0];
          CFG_PIXELS_PER_LINE:  timing_regs.pixels_per_line  = cfg_data_i[9:0];
          CFG_VISIBLE_LINES:    timing_regs.visible_lines    = cfg_data_i[8:0];
          CFG_FRAME_LINES:      timing_regs.frame_lines      = cfg_data_i[8:0];
          default: ;
        endcase
      end
      if (!cfg_valid_i || cfg_ready_o) begin
        if (reg_writes.size() != 0) begin
          w = reg_writes.pop_front();
          cfg_valid_i <= 1'b1;
          cfg_index_i <= w.idx;
          cfg_data_i  <= w.val;
        end else begin
          cfg_valid_i <= 1'b0;
        end
      end
    end
  end

  // one long receiver hold-off so the pipe backs up into the input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cnt  <= '0;
      hold_used <= 1'b0;
    end else if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 7'd1;
    end else if (hold_go && !hold_used && s_axis_tvalid) begin
      hold_cnt  <= 7'd80;
      hold_used <= 1'b1;
    end
  end

  assign rx_hold = (hold_cnt != 0);

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    int unsigned gap;
    result_t     got, want;
    string       bad;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      rx_wait       <= 0;
    end else begin
      gap = (rx_wait != 0) ? rx_wait - 1 : 0;
      if (m_axis_tvalid && m_axis_tready) begin
        got = result_t'(m_axis_tdata);
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("result %0d arrived with nothing expected: got %h", results_seen, got);
        end else begin
          want = expected_results.pop_front();
          bad  = "";
          if (got.sync_level    !== want.sync_level)    bad = {bad, " sync_level"};
          if (got.pixel_strobe  !== want.pixel_strobe)  bad = {bad, " pixel_strobe"};
          if (got.pixel_index   !== want.pixel_index)   bad = {bad, " pixel_index"};
          if (got.buffer_select !== want.buffer_select) bad = {bad, " buffer_select"};
          if (got.line_number   !== want.line_number)   bad = {bad, " line_number"};
          if (got.frame_count   !== want.frame_count)   bad = {bad, " frame_count"};
          if (got.line_start    !== want.line_start)    bad = {bad, " line_start"};
          if (got.blanked       !== want.blanked)       bad = {bad, " blanked"};
          if (bad != "") begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("result %0d mismatch in%s: expected %h, got %h",
                       results_seen, bad, want, got);
          end
          line_events += want.line_start;
          strobes     += want.pixel_strobe;
        end
        gap = idle_en ? $urandom_range(0, 7) : 0;
      end
      rx_wait       <= gap;
      m_axis_tready <= (gap == 0) && !rx_hold;
    end
  end

  // watchdog on transaction activity
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_results.size());
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic wait_drained();
    while (tick_q.size() != 0 || s_axis_tvalid || expected_results.size() != 0 ||
           reg_writes.size() != 0 || cfg_valid_i)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic run_phase(input cfg_t c, input int unsigned n, input int unsigned zero_pct);
    reg_writes.push_back('{CFG_LINE_PERIOD,      c.line_period});
    reg_writes.push_back('{CFG_SHORT_SYNC_END,   c.short_sync_end});
    reg_writes.push_back('{CFG_LONG_SYNC_END,    c.long_sync_end});
    reg_writes.push_back('{CFG_LINE_EVENT_POINT, c.line_event_point});
    reg_writes.push_back('{CFG_PIXEL_PERIOD,     16'(c.pixel_period)});
    reg_writes.push_back('{CFG_PIXELS_PER_LINE,  16'(c.pixels_per_line)});
    reg_writes.push_back('{CFG_VISIBLE_LINES,    16'(c.visible_lines)});
    reg_writes.push_back('{CFG_FRAME_LINES,      16'(c.frame_lines)});
    wait_drained();
    idle_en = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < n; i++) tick_q.push_back($urandom_range(0, 99) >= zero_pct);
    wait_drained();
    setups++;
  endtask

  function automatic cfg_t random_timing();
    cfg_t c;
    c.line_period      = 16'($urandom_range(1, 24));
    c.short_sync_end   = 16'($urandom_range(0, c.line_period + 2));
    c.long_sync_end    = 16'($urandom_range(0, c.line_period + 2));
    c.line_event_point = 16'($urandom_range(0, c.line_period));
    c.pixel_period     = 8'($urandom_range(0, 5));
    c.pixels_per_line  = 10'($urandom_range(0, 12));
    c.visible_lines    = 9'($urandom_range(1, 8));
    c.frame_lines      = 9'($urandom_range(2, 20));
    return c;
  endfunction

  initial begin
    wait (rst_ni === 1'b1);
    @(negedge clk_i);

    // reset timing, held and live ticks
    for (int i = 0; i < 6; i++) tick_q.push_back(RESET_PATTERN[i]);
    wait_drained();

    // zero line period, widest pixel run, highest line limits
    run_phase('{16'd0, 16'hFFFF, 16'd0, 16'd5, 8'd255, 10'd1023, 9'd511, 9'd511}, 10, 10);
    // event point beyond the line, narrowest frame
    run_phase('{16'hFFFF, 16'd0, 16'hFFFF, 16'hFFFF, 8'd1, 10'd1, 9'd1, 9'd2}, 8, 10);
    // two-line frame, zero pixel period, no line starts a pixel run
    run_phase('{16'd3, 16'd1, 16'd3, 16'd0, 8'd0, 10'd1, 9'd1, 9'd2}, 60, 10);
    // short frame passing through the broad sync lines
    run_phase('{16'd5, 16'd1, 16'd4, 16'd4, 8'd2, 10'd3, 9'd3, 9'd10}, 150, 10);
    // a line event every tick, line counter wraps through 511, run restarts
    hold_go = 1'b1;
    run_phase('{16'd1, 16'd0, 16'hFFFF, 16'd0, 8'd0, 10'd1023, 9'd511, 9'd511}, 600, 3);
    for (int p = 0; p < 3; p++) run_phase(random_timing(), 130, 10);

    wait_drained();
    repeat (8) @(negedge clk_i);
    $display("covered %0d ticks over %0d timing setups", ticks_taken, setups);
    $display("saw %0d line events, %0d pixel strobes, frame count %0d",
             line_events, strobes, frames);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: composite_video_timing_generator_unit.f
hdl/cvtg_pkg.sv
hdl/cvtg_cfg.sv
hdl/cvtg_core.sv
hdl/composite_video_timing_generator_unit.sv
tb/composite_video_timing_generator_unit_tb.sv
